@@ design/dma_tx_ring_buffer_core_macros.svh @@
// ----------------------------------------------------------------------------
// DMA transmit ring buffer assertion macros
// Concurrent assertion wrappers used by the ring buffer back end; they
// vanish when the design is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef DMA_TX_RING_BUFFER_CORE_MACROS_SVH
`define DMA_TX_RING_BUFFER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Holds at every clock edge outside reset.
`define DTRB_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Consequent holds in the same cycle as the antecedent.
`define DTRB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define DTRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DTRB_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define DTRB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DTRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/dtrb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA transmit ring buffer package
// Item, result and command types and fixed constants of the ring buffer.
// ----------------------------------------------------------------------------
package dtrb_pkg;

	localparam int unsigned FIELD_W = 10;
	localparam int unsigned CFG_W   = 4;

	localparam logic [CFG_W-1:0]   RING_LOG2_RESET = 4'd10;
	localparam logic [FIELD_W-1:0] COUNT_MAX       = 10'd1023;

	typedef enum logic {
		MODE_DATA     = 1'b0,
		MODE_COMPLETE = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		CMD_BYTE     = 2'd0,
		CMD_LAST     = 2'd1,
		CMD_COMPLETE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       last_byte;
		logic       dma_counter_zero;
	} in_item_t;

	typedef struct packed {
		logic               write_done;
		logic [FIELD_W-1:0] accepted_count;
		logic               dma_start;
		logic [FIELD_W-1:0] start_offset;
		logic [FIELD_W-1:0] start_length;
	} result_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       dzero;
	} cmd_t;

endpackage

@@ design/dtrb_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-entry queue
// Small first-in first-out buffer that decouples two pipeline sections.
// ----------------------------------------------------------------------------
module dtrb_queue #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t din,
	input  logic  pop,
	output logic  empty,
	output item_t dout
);

	item_t       entries_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ design/dtrb_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer front end
// Accepts input items, sorts them into commands and queues them for the
// back end.
// ----------------------------------------------------------------------------
module dtrb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  dtrb_pkg::in_item_t item,
	input  logic              cmd_pop,
	output logic              cmd_empty,
	output dtrb_pkg::cmd_t    cmd
);

	dtrb_pkg::cmd_t cmd_in;

	// A completion event ignores the byte fields; a data byte is either
	// an ordinary byte or the one that closes its request.
	always_comb begin
		cmd_in.data  = item.data_byte;
		cmd_in.dzero = item.dma_counter_zero;
		priority if (item.mode == dtrb_pkg::MODE_COMPLETE) begin
			cmd_in.kind = dtrb_pkg::CMD_COMPLETE;
		end else if (item.last_byte) begin
			cmd_in.kind = dtrb_pkg::CMD_LAST;
		end else begin
			cmd_in.kind = dtrb_pkg::CMD_BYTE;
		end
	end

	dtrb_queue #(
		.item_t(dtrb_pkg::cmd_t)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (cmd_in),
		.pop   (cmd_pop),
		.empty (cmd_empty),
		.dout  (cmd)
	);

endmodule

@@ design/dtrb_back.sv @@
`timescale 1ns / 1ps
`include "dma_tx_ring_buffer_core_macros.svh"
// ----------------------------------------------------------------------------
// Ring buffer back end
// Holds the ring state and byte store, executes one command per cycle while the
// result queue has room and produces write-done and DMA start results.
// ----------------------------------------------------------------------------
module dtrb_back #(
	parameter int unsigned MAX_SIZE_LOG2 = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dtrb_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         cmd_empty,
	input  dtrb_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	input  logic                         res_full,
	output logic                         res_push,
	output dtrb_pkg::result_t            res
);

	localparam int unsigned PW    = MAX_SIZE_LOG2;
	localparam int unsigned LW    = PW + 1;
	localparam int unsigned DEPTH = 1 << PW;

	logic [dtrb_pkg::CFG_W-1:0]   cfg_q;
	logic [PW-1:0]                wp_q;
	logic [PW-1:0]                rp_q;
	logic [LW-1:0]                inflight_q;
	logic [dtrb_pkg::FIELD_W-1:0] cnt_q;
	logic [7:0]                   store_q [DEPTH];

	logic [dtrb_pkg::CFG_W-1:0]   k_eff;
	logic [LW-1:0]                size;
	logic [PW-1:0]                mask;
	logic                         proc;
	logic                         is_complete;
	logic [PW-1:0]                wp_inc;
	logic                         has_room;
	logic [PW-1:0]                wp_after;
	logic [dtrb_pkg::FIELD_W-1:0] cnt_sat;
	logic [PW-1:0]                rp_adv;
	logic [PW-1:0]                chunk_head;
	logic [PW-1:0]                chunk_tail;
	logic [LW-1:0]                chunk_len;
	logic                         do_store;
	logic [PW-1:0]                wp_d;
	logic [PW-1:0]                rp_d;
	logic [LW-1:0]                inflight_d;
	logic [dtrb_pkg::FIELD_W-1:0] cnt_d;

	// Out-of-range ring sizes are clamped to the supported range.
	always_comb begin
		priority if (cfg_q == '0) begin
			k_eff = dtrb_pkg::CFG_W'(1);
		end else if (32'(cfg_q) > PW) begin
			k_eff = dtrb_pkg::CFG_W'(PW);
		end else begin
			k_eff = cfg_q;
		end
	end

	assign size = LW'(1) << k_eff;
	assign mask = PW'(size - LW'(1));

	assign proc        = !cmd_empty && !res_full;
	assign cmd_pop     = proc;
	assign is_complete = (cmd.kind == dtrb_pkg::CMD_COMPLETE);

	// Write side: one slot always stays empty.
	assign wp_inc   = (wp_q + PW'(1)) & mask;
	assign has_room = (wp_inc != rp_q);
	assign wp_after = has_room ? wp_inc : wp_q;
	assign cnt_sat  = (has_room && (cnt_q != dtrb_pkg::COUNT_MAX)) ?
		cnt_q + dtrb_pkg::FIELD_W'(1) : cnt_q;

	// Read side: a completion retires the in-flight chunk.
	assign rp_adv = (rp_q + PW'(inflight_q)) & mask;

	// Chunk runs to the head, or to the ring end when wrapped or empty.
	assign chunk_head = is_complete ? wp_q : wp_after;
	assign chunk_tail = is_complete ? rp_adv : rp_q;
	assign chunk_len  = (chunk_head > chunk_tail) ? LW'(chunk_head - chunk_tail) :
		size - LW'(chunk_tail);

	always_comb begin
		wp_d       = wp_q;
		rp_d       = rp_q;
		inflight_d = inflight_q;
		cnt_d      = cnt_q;
		do_store   = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		if (proc) begin
			unique case (cmd.kind)
				dtrb_pkg::CMD_BYTE: begin
					do_store = has_room;
					wp_d     = wp_after;
					cnt_d    = cnt_sat;
				end
				dtrb_pkg::CMD_LAST: begin
					do_store           = has_room;
					wp_d               = wp_after;
					cnt_d              = '0;
					res_push           = 1'b1;
					res.write_done     = 1'b1;
					res.accepted_count = cnt_sat;
					if ((cnt_sat != '0) && cmd.dzero) begin
						res.dma_start    = 1'b1;
						res.start_offset = dtrb_pkg::FIELD_W'(chunk_tail);
						res.start_length = dtrb_pkg::FIELD_W'(chunk_len);
						inflight_d       = chunk_len;
					end
				end
				dtrb_pkg::CMD_COMPLETE: begin
					rp_d = rp_adv;
					if (rp_adv != wp_q) begin
						res_push         = 1'b1;
						res.dma_start    = 1'b1;
						res.start_offset = dtrb_pkg::FIELD_W'(chunk_tail);
						res.start_length = dtrb_pkg::FIELD_W'(chunk_len);
						inflight_d       = chunk_len;
					end else begin
						inflight_d = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// A register write re-initialises the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= dtrb_pkg::RING_LOG2_RESET;
			wp_q       <= '0;
			rp_q       <= '0;
			inflight_q <= '0;
			cnt_q      <= '0;
		end else if (cfg_we) begin
			cfg_q      <= cfg_wdata;
			wp_q       <= '0;
			rp_q       <= '0;
			inflight_q <= '0;
			cnt_q      <= '0;
		end else begin
			wp_q       <= wp_d;
			rp_q       <= rp_d;
			inflight_q <= inflight_d;
			cnt_q      <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_store) begin
			store_q[wp_q] <= cmd.data;
		end
	end

	`DTRB_ASSERT_ALWAYS(a_ptr_in_ring, clk, arst_n, ((wp_q & ~mask) == '0) && ((rp_q & ~mask) == '0), "ring pointer outside ring")
	`DTRB_ASSERT_ALWAYS(a_inflight_bound, clk, arst_n, inflight_q <= size, "in-flight length exceeds ring size")
	`DTRB_ASSERT_IMPL(a_no_push_full, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	`DTRB_ASSERT_NEXT(a_idle_clears, clk, arst_n, proc && is_complete && !res_push && !cfg_we, inflight_q == '0, "empty ring kept in-flight length")
	`DTRB_ASSERT_NEXT(a_close_clears, clk, arst_n, proc && (cmd.kind == dtrb_pkg::CMD_LAST) && !cfg_we, cnt_q == '0, "closed request kept its count")

endmodule

@@ design/dma_tx_ring_buffer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA transmit ring buffer core
// Byte ring that buffers transmit data and issues DMA chunk start commands.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle while the command queue is not full
// and delivers at most one result per item, so with pop held high it sustains
// a throughput of one item per cycle; the ring update in the back end sets
// that figure. An item is registered into the command queue, then passes
// through the back end and is registered into the result queue before it
// becomes a result. Each item is either a data byte of a write request or a DMA
// transfer-complete event. Data bytes are stored at the write pointer while
// the ring has room, with one slot always kept empty, and are silently dropped
// once it is full. The byte that closes a request produces a result carrying
// the number of bytes stored for that request (saturating at 1023); if any
// were stored and the DMA counter read zero, the result also carries a start
// command whose offset is the read pointer and whose length runs to the write
// pointer, or to the end of the ring when the data wraps. A transfer-complete
// event retires the in-flight chunk and, when more data is waiting, produces a
// start command for the next chunk; with an empty ring it produces no result.
// The ring size register may only be written while the core is idle, and a
// write also resets the pointers and counts. There is no clearing pass after
// reset: the byte store is never read back by the core, only written.
// ----------------------------------------------------------------------------
module dma_tx_ring_buffer_core #(
	parameter int unsigned MAX_SIZE_LOG2 = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input items
	input  logic                       push,
	output logic                       full,
	input  dtrb_pkg::in_item_t         item,
	// Results
	output logic                       empty,
	input  logic                       pop,
	output dtrb_pkg::result_t          result,
	// Ring size register
	input  logic                       cfg_we,
	input  logic [dtrb_pkg::CFG_W-1:0] cfg_wdata
);

	logic              cmd_empty;
	logic              cmd_pop;
	dtrb_pkg::cmd_t    cmd;
	logic              res_full;
	logic              res_push;
	dtrb_pkg::result_t res;

	// Front end: classifies each item and queues it as a command, so that the
	// input side keeps moving while the back end waits on the result queue.
	dtrb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd      (cmd)
	);

	// Back end: owns the pointers, the request count and the byte store, and
	// retires one command per cycle whenever the result queue has room.
	dtrb_back #(
		.MAX_SIZE_LOG2(MAX_SIZE_LOG2)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// Result queue: registered output that lets a finished result wait for pop
	// while new items keep flowing in.
	dtrb_queue #(
		.item_t(dtrb_pkg::result_t)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (res),
		.pop   (pop),
		.empty (empty),
		.dout  (result)
	);

endmodule
